// ===== src/ring_list_cursor_editor_unit_macros.svh =====
// Assertion macros for the ring list cursor editor.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RING_LIST_CURSOR_EDITOR_UNIT_MACROS_SVH
`define RING_LIST_CURSOR_EDITOR_UNIT_MACROS_SVH

// General form with an explicit clock and active-low reset.
`define RLCE_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Short form for modules that use the house clock and reset names.
`define RLCE_ASSERT(lbl, prop, msg) `RLCE_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/rlce_pkg.sv =====
// Shared constants, types and codes of the ring list cursor editor.
// No dependencies; imported by the interfaces, the sequencer, the top level and the testbench.
`default_nettype none

package rlce_pkg;

  localparam int NODE_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int USED_W     = $clog2(NODE_SLOTS + 1);
  localparam int NAME_W     = 64;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [NAME_W-1:0] name_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_NEXT   = 3'd1,
    CMD_PREV   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_INSERT = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SHOWN = 2'd0,
    ST_EQUAL = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Port requests to one link memory: one write and one read per cycle.
  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    slot_t raddr;
  } link_req_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    name_t wdata;
    slot_t raddr;
  } name_req_t;

endpackage

`default_nettype wire

// ===== src/rlce_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on rlce_pkg for field widths.
`default_nettype none

interface rlce_cmd_if import rlce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  name_t              city_name;

  modport source (output valid, output command, output city_name, input ready);
  modport sink (input valid, input command, input city_name, output ready);
endinterface

interface rlce_res_if import rlce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  name_t               left_name;
  name_t               right_name;

  modport source (output valid, output status, output left_name, output right_name,
                  input ready);
  modport sink (input valid, input status, input left_name, input right_name,
                output ready);
endinterface

`default_nettype wire

// ===== src/rlce_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module rlce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/rlce_seq.sv =====
// Command sequencer: cursor and fill count, memory port control and result register.
// Depends on rlce_pkg, rlce_if and the assertion macro header.
`default_nettype none
`include "ring_list_cursor_editor_unit_macros.svh"

module rlce_seq import rlce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rlce_cmd_if.sink          cmd_i,
  rlce_res_if.source        res_o,
  output link_req_t         nxt_req_o,
  output link_req_t         prv_req_o,
  output name_req_t         name_req_o,
  input  slot_t             nxt_rdata_i,
  input  slot_t             prv_rdata_i,
  input  name_t             name_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK1,
    S_LINK2,
    S_RM,
    S_RD_LINKS,
    S_NAME_L,
    S_NAME_R,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  cmd_e    cmd_q, cmd_d;
  name_t   cname_q, cname_d;
  slot_t   cursor_q, cursor_d;
  used_t   used_q, used_d;
  slot_t   tgt_q, tgt_d;
  slot_t   right_q, right_d;
  name_t   left_q, left_d;
  status_e stat_q, stat_d;

  logic    out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  name_t   out_left_q, out_left_d;
  name_t   out_right_q, out_right_d;

  cmd_e  cmd_in;
  logic  cmd_fire;
  logic  out_free;
  logic  full;
  logic  empty;
  slot_t new_slot;
  slot_t link_a;

  assign cmd_in   = cmd_e'(cmd_i.command);
  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign full     = (used_q == used_t'(NODE_SLOTS));
  assign empty    = (used_q == '0);
  assign new_slot = used_q[SLOT_W-1:0];
  // A load links the new node after the cursor's left neighbour, an insert after the cursor.
  assign link_a   = (cmd_q == CMD_LOAD) ? prv_rdata_i : cursor_q;

  assign cmd_i.ready      = (state_q == S_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_status_q;
  assign res_o.left_name  = out_left_q;
  assign res_o.right_name = out_right_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cname_d      = cname_q;
    cursor_d     = cursor_q;
    used_d       = used_q;
    tgt_d        = tgt_q;
    right_d      = right_q;
    left_d       = left_q;
    stat_d       = stat_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;

    nxt_req_o  = '{we: 1'b0, waddr: cursor_q, wdata: '0, raddr: cursor_q};
    prv_req_o  = '{we: 1'b0, waddr: cursor_q, wdata: '0, raddr: cursor_q};
    name_req_o = '{we: 1'b0, waddr: new_slot, wdata: cname_q, raddr: right_q};

    case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          cmd_d   = cmd_in;
          cname_d = cmd_i.city_name;
          case (cmd_in)
            CMD_LOAD: begin
              if (full) begin
                stat_d  = ST_FULL;
                state_d = S_FINISH;
              end else if (empty) begin
                // The first node forms a ring of one at slot 0.
                name_req_o.we    = 1'b1;
                name_req_o.waddr = '0;
                name_req_o.wdata = cmd_i.city_name;
                nxt_req_o.we     = 1'b1;
                nxt_req_o.waddr  = '0;
                prv_req_o.we     = 1'b1;
                prv_req_o.waddr  = '0;
                cursor_d         = '0;
                used_d           = used_q + used_t'(1);
              end else begin
                state_d = S_LINK1;
              end
            end
            CMD_NEXT, CMD_PREV, CMD_REMOVE: begin
              if (empty) begin
                stat_d  = ST_EMPTY;
                state_d = S_FINISH;
              end else begin
                state_d = S_LINK1;
              end
            end
            CMD_INSERT: begin
              if (empty) begin
                stat_d  = ST_EMPTY;
                state_d = S_FINISH;
              end else if (full) begin
                stat_d  = ST_FULL;
                state_d = S_FINISH;
              end else begin
                state_d = S_LINK1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_LINK1: begin
        stat_d = ST_SHOWN;
        case (cmd_q)
          CMD_LOAD, CMD_INSERT: begin
            nxt_req_o.we     = 1'b1;
            nxt_req_o.waddr  = link_a;
            nxt_req_o.wdata  = new_slot;
            prv_req_o.we     = 1'b1;
            prv_req_o.waddr  = new_slot;
            prv_req_o.wdata  = link_a;
            name_req_o.we    = 1'b1;
            tgt_d            = (cmd_q == CMD_LOAD) ? cursor_q : nxt_rdata_i;
            state_d          = S_LINK2;
          end
          CMD_NEXT: begin
            cursor_d = nxt_rdata_i;
            state_d  = S_RD_LINKS;
          end
          CMD_PREV: begin
            cursor_d = prv_rdata_i;
            state_d  = S_RD_LINKS;
          end
          CMD_REMOVE: begin
            if (nxt_rdata_i == cursor_q) begin
              state_d = S_RD_LINKS;
            end else begin
              // Fetch the link that skips over the right neighbour.
              nxt_req_o.raddr = nxt_rdata_i;
              state_d         = S_RM;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_LINK2: begin
        nxt_req_o.we    = 1'b1;
        nxt_req_o.waddr = new_slot;
        nxt_req_o.wdata = tgt_q;
        prv_req_o.we    = 1'b1;
        prv_req_o.waddr = tgt_q;
        prv_req_o.wdata = new_slot;
        used_d          = used_q + used_t'(1);
        state_d         = (cmd_q == CMD_LOAD) ? S_IDLE : S_RD_LINKS;
      end

      S_RM: begin
        nxt_req_o.we    = 1'b1;
        nxt_req_o.waddr = cursor_q;
        nxt_req_o.wdata = nxt_rdata_i;
        prv_req_o.we    = 1'b1;
        prv_req_o.waddr = nxt_rdata_i;
        prv_req_o.wdata = cursor_q;
        state_d         = S_RD_LINKS;
      end

      S_RD_LINKS: begin
        state_d = S_NAME_L;
      end

      S_NAME_L: begin
        name_req_o.raddr = prv_rdata_i;
        right_d          = nxt_rdata_i;
        state_d          = S_NAME_R;
      end

      S_NAME_R: begin
        left_d  = name_rdata_i;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // The right name stays on the read port while the result register is busy.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_left_d  = '0;
          out_right_d = '0;
          if (stat_q != ST_SHOWN) begin
            out_status_d = stat_q;
          end else if (left_q == name_rdata_i) begin
            out_status_d = ST_EQUAL;
          end else begin
            out_status_d = ST_SHOWN;
            out_left_d   = left_q;
            out_right_d  = name_rdata_i;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_LOAD;
      cname_q      <= '0;
      cursor_q     <= '0;
      used_q       <= '0;
      tgt_q        <= '0;
      right_q      <= '0;
      left_q       <= '0;
      stat_q       <= ST_SHOWN;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_SHOWN;
      out_left_q   <= '0;
      out_right_q  <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      cname_q      <= cname_d;
      cursor_q     <= cursor_d;
      used_q       <= used_d;
      tgt_q        <= tgt_d;
      right_q      <= right_d;
      left_q       <= left_d;
      stat_q       <= stat_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_left_q   <= out_left_d;
      out_right_q  <= out_right_d;
    end
  end

  `RLCE_ASSERT(a_cursor_alloc, (used_q != '0) |-> (used_t'(cursor_q) < used_q), "cursor on unallocated slot")
  `RLCE_ASSERT(a_used_step, 1'b1 |=> ((used_q == $past(used_q)) || (used_q == $past(used_q) + 1'b1)), "fill count jumped")
  `RLCE_ASSERT(a_ring_kept, (used_q != '0) |=> (used_q != '0), "ring became empty")
  `RLCE_ASSERT(a_link_wr, (!nxt_req_o.we || (used_t'(nxt_req_o.waddr) <= used_q)) && (!prv_req_o.we || (used_t'(prv_req_o.waddr) <= used_q)), "link write beyond allocated slots")

endmodule

`default_nettype wire

// ===== src/ring_list_cursor_editor_unit.sv =====
// Every move, remove and insert gives one result, also when it is rejected; a load gives
// a result only when the store is full, and undefined command codes give none.
// Each command walks dependent reads and writes of the node memories, and a new command
// is accepted only in the idle state.
// Reset clears the cursor, the fill count and the result register; the node memories
// are not cleared and need no clearing pass.
`default_nettype none

module ring_list_cursor_editor_unit import rlce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlce_cmd_if.sink   cmd_i,
  rlce_res_if.source res_o
);

  link_req_t nxt_req;
  link_req_t prv_req;
  name_req_t name_req;
  slot_t     nxt_rdata;
  slot_t     prv_rdata;
  name_t     name_rdata;

  rlce_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .res_o        (res_o),
    .nxt_req_o    (nxt_req),
    .prv_req_o    (prv_req),
    .name_req_o   (name_req),
    .nxt_rdata_i  (nxt_rdata),
    .prv_rdata_i  (prv_rdata),
    .name_rdata_i (name_rdata)
  );

  rlce_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_req.we),
    .waddr_i (nxt_req.waddr),
    .wdata_i (nxt_req.wdata),
    .raddr_i (nxt_req.raddr),
    .rdata_o (nxt_rdata)
  );

  rlce_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_req.we),
    .waddr_i (prv_req.waddr),
    .wdata_i (prv_req.wdata),
    .raddr_i (prv_req.raddr),
    .rdata_o (prv_rdata)
  );

  rlce_ram #(.WIDTH(NAME_W), .DEPTH(NODE_SLOTS)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_req.we),
    .waddr_i (name_req.waddr),
    .wdata_i (name_req.wdata),
    .raddr_i (name_req.raddr),
    .rdata_o (name_rdata)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ring list cursor editor: random and directed commands,
// with the results checked against a cycle-free model of the ring and cursor.
// Depends on rlce_pkg, the rlce_cmd_if and rlce_res_if interfaces and the editor top level.

module tb_top;
  import rlce_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
  localparam int IDLE_PCT      = 24;
  localparam int CALM_START    = 6000;
  localparam int CALM_END      = 8000;
  localparam int HOLD_AT       = 2500;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_AT      = 500;
  localparam int AFTER_FULL    = 60;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [CMD_W-1:0] op;
    name_t            nm;
    bit               drain;
  } cmd_item_t;

  typedef struct {
    status_e status;
    name_t   left;
    name_t   right;
  } view_t;

  logic clk_i;
  logic rst_ni;

  rlce_cmd_if cmd_if ();
  rlce_res_if res_if ();

  ring_list_cursor_editor_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  cmd_item_t cmd_pending[$];
  view_t     expected_views[$];
  int        cmds_total    = 0;
  int        cmds_accepted = 0;
  int        mismatches    = 0;
  int        cyc           = 0;
  int        slots_granted = 0;
  bit        cmd_took      = 1'b0;
  bit        rx_hold       = 1'b0;
  logic      calm;

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  // Shadow copy of the node memories, cursor and fill count.
  name_t ring_names [NODE_SLOTS];
  slot_t ring_next  [NODE_SLOTS];
  slot_t ring_prev  [NODE_SLOTS];
  slot_t cur_slot   = '0;
  used_t fill_cnt   = '0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void join_links(slot_t a, slot_t b);
    ring_next[a] = b;
    ring_prev[b] = a;
  endfunction

  function automatic void push_view(status_e st);
    view_t v;
    name_t l, r;
    v.status = st;
    v.left   = '0;
    v.right  = '0;
    if (st == ST_SHOWN) begin
      l = ring_names[ring_prev[cur_slot]];
      r = ring_names[ring_next[cur_slot]];
      if (l == r) begin
        v.status = ST_EQUAL;
      end else begin
        v.left  = l;
        v.right = r;
      end
    end
    expected_views.push_back(v);
  endfunction

  // Applies one accepted command to the shadow ring and queues the view it reports.
  function automatic void ring_step(logic [CMD_W-1:0] op, name_t nm);
    slot_t c, n, r;
    c = cur_slot;
    if (op > CMD_INSERT) return;
    if (op == CMD_LOAD) begin
      if (fill_cnt == NODE_SLOTS) begin
        push_view(ST_FULL);
        return;
      end
      n = fill_cnt[SLOT_W-1:0];
      ring_names[n] = nm;
      fill_cnt++;
      if (n == 0) begin
        ring_next[0] = '0;
        ring_prev[0] = '0;
        cur_slot     = '0;
      end else begin
        // The new node goes just left of the cursor.
        join_links(ring_prev[c], n);
        join_links(n, c);
      end
      return;
    end
    if (fill_cnt == 0) begin
      push_view(ST_EMPTY);
      return;
    end
    case (op)
      CMD_NEXT: cur_slot = ring_next[c];
      CMD_PREV: cur_slot = ring_prev[c];
      CMD_REMOVE: begin
        r = ring_next[c];
        if (r != c) join_links(c, ring_next[r]);
      end
      default: begin
        if (fill_cnt == NODE_SLOTS) begin
          push_view(ST_FULL);
          return;
        end
        n = fill_cnt[SLOT_W-1:0];
        ring_names[n] = nm;
        fill_cnt++;
        r = ring_next[c];
        join_links(c, n);
        join_links(n, r);
      end
    endcase
    push_view(ST_SHOWN);
  endfunction

  function automatic name_t pick_name();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h5345_4f55_4c00_0000;
      3:       return 64'h5041_5249_5300_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Tracks slot usage at generation time so the stimulus knows when the store fills.
  task automatic add_cmd(input logic [CMD_W-1:0] op, input name_t nm, input bit drain = 1'b0);
    cmd_item_t it;
    it.op    = op;
    it.nm    = nm;
    it.drain = drain;
    cmd_pending.push_back(it);
    cmds_total++;
    if (slots_granted < NODE_SLOTS &&
        (op == CMD_LOAD || (op == CMD_INSERT && slots_granted > 0)))
      slots_granted++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = '0;
    cmd_if.city_name = '0;
    res_if.ready     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Command driver.
  always @(negedge clk_i) begin
    cmd_item_t nxt_cmd;
    if (rst_ni) begin
      if (!cmd_if.valid || cmd_took) begin
        if (cmd_pending.size() != 0 &&
            (!cmd_pending[0].drain || expected_views.size() == 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt_cmd = cmd_pending.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.command   <= nxt_cmd.op;
          cmd_if.city_name <= nxt_cmd.nm;
        end else begin
          cmd_if.valid     <= 1'b0;
          cmd_if.command   <= CMD_W'($urandom);
          cmd_if.city_name <= {$urandom, $urandom};
        end
      end
    end
  end

  // Result receiver backpressure.
  always @(negedge clk_i) begin
    if (rst_ni)
      res_if.ready <= !rx_hold && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: check results before the same edge's command adds a new expectation.
  always @(posedge clk_i) begin
    view_t want;
    if (rst_ni) begin
      cyc++;
      cmd_took <= cmd_if.valid && cmd_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d left %h right %h",
                                    res_if.status, res_if.left_name, res_if.right_name));
        end else begin
          want = expected_views.pop_front();
          if (res_if.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %s",
                                      res_if.status, want.status.name()));
          if (res_if.left_name !== want.left)
            report_mismatch($sformatf("left_name got %h expected %h",
                                      res_if.left_name, want.left));
          if (res_if.right_name !== want.right)
            report_mismatch($sformatf("right_name got %h expected %h",
                                      res_if.right_name, want.right));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        cmds_accepted++;
        ring_step(cmd_if.command, cmd_if.city_name);
      end
    end
  end

  // Long receiver stall while commands keep coming, so the input backs up.
  initial begin
    wait (rst_ni);
    repeat (HOLD_AT) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int pick;
    int extra;
    int n_rand;
    logic [CMD_W-1:0] op;

    // Commands on an empty ring, then the undefined codes.
    add_cmd(CMD_NEXT, '1);
    add_cmd(CMD_PREV, '0);
    add_cmd(CMD_REMOVE, '0);
    add_cmd(CMD_INSERT, '1);
    for (int k = CMD_UNDEF_LO; k <= CMD_UNDEF_HI; k++)
      add_cmd(k[CMD_W-1:0], '1);
    // One node: both neighbors are the node itself, and removal does nothing.
    add_cmd(CMD_LOAD, '1);
    add_cmd(CMD_NEXT, '0);
    add_cmd(CMD_REMOVE, '0);
    add_cmd(CMD_PREV, '0);
    // Two nodes show equal neighbors; an insert and a remove then grow and shrink the ring.
    add_cmd(CMD_LOAD, '0);
    add_cmd(CMD_NEXT, '0);
    add_cmd(CMD_INSERT, 64'h0123_4567_89ab_cdef);
    add_cmd(CMD_PREV, '0);
    add_cmd(CMD_REMOVE, '0);
    // A repeated name goes into a larger ring; moves, an insert and a remove follow.
    add_cmd(CMD_LOAD, 64'h0123_4567_89ab_cdef);
    add_cmd(CMD_LOAD, 64'hfedc_ba98_7654_3210);
    add_cmd(CMD_NEXT, '0);
    add_cmd(CMD_NEXT, '0);
    add_cmd(CMD_INSERT, 64'h8000_0000_0000_0001);
    add_cmd(CMD_REMOVE, '0);
    add_cmd(CMD_PREV, '0);

    // Random part runs until the store is full and then keeps going for a while.
    extra  = 0;
    n_rand = 0;
    while (slots_granted < NODE_SLOTS || extra < AFTER_FULL) begin
      if (slots_granted >= NODE_SLOTS) extra++;
      pick = $urandom_range(99);
      if (pick < 55)      op = CMD_INSERT;
      else if (pick < 90) op = CMD_LOAD;
      else if (pick < 93) op = CMD_NEXT;
      else if (pick < 96) op = CMD_PREV;
      else if (pick < 99) op = CMD_REMOVE;
      else                op = CMD_W'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
      add_cmd(op, pick_name(), n_rand == DRAIN_AT);
      n_rand++;
    end

    wait (rst_ni);
    while (!(cmds_accepted == cmds_total && expected_views.size() == 0))
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_views.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_views.size()));
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rlce_pkg.sv
src/rlce_if.sv
src/rlce_ram.sv
src/rlce_seq.sv
src/ring_list_cursor_editor_unit.sv
dv/tb_top.sv
